@@ rtl/core/ccsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsb_pkg
// Shared types and constants of the character-class set builder.
// ----------------------------------------------------------------------------
package ccsb_pkg;

  // Default alphabet size; the legal range is 64 to 256.
  localparam int ALPHABET_SIZE_DEF = 256;

  // Bitmap geometry: up to four 64-bit words.
  localparam int WORD_BITS = 64;
  localparam int MAX_WORDS = 4;
  localparam int WIDX_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 9;

  // Stream widths.
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 1;

  // Token kinds carried on the input tuser.
  typedef enum logic [1:0] {
    TOK_LETTER  = 2'd0,
    TOK_MINUS   = 2'd1,
    TOK_BRACKET = 2'd2,
    TOK_OTHER   = 2'd3
  } token_kind_t;

  // Result status carried on the output tuser.
  localparam logic STATUS_CLASS = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

endpackage

@@ rtl/core/char_class_set_builder.sv @@
// ----------------------------------------------------------------------------
// char_class_set_builder
// Builds the membership bitmap of a regex bracket expression from its tokens
// and emits it as 64-bit words with the member count, or one error result.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Signals                      | Contents
// ---------+-----+------------------------------+-------------------------------
// s_*      | in  | s_tvalid s_tready s_tdata    | tdata: token_char;
//          |     | s_tuser                      | tuser: token_kind
// m_*      | out | m_tvalid m_tready m_tdata    | tdata: word_index, member_mask,
//          |     | m_tuser m_tlast              | char_count; tuser: status;
//          |     |                              | tlast: last
//
// A letter or a minus is taken in the idle state. A range end is taken there,
// then the shared word mask unit sets each 64-character word the range touches
// (one to four) in turn. A closing bracket starts a pass in which the same unit
// counts the members of each word, then the words are loaded one by one. An
// error loads its result afterwards; output stalls delay only these loads.
// Synchronous reset clears the bitmap and waits for a first letter.
// ----------------------------------------------------------------------------
module char_class_set_builder #(
  parameter int ALPHABET_SIZE = ccsb_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input token stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ccsb_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] token_char
  input  logic [ccsb_pkg::IN_TUSER_W-1:0]  s_tuser,   // [1:0] token_kind
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ccsb_pkg::OUT_TDATA_W-1:0] m_tdata,   // [1:0] word_index,
                                                      // [65:2] member_mask,
                                                      // [74:66] char_count,
                                                      // [79:75] zero
  output logic [ccsb_pkg::OUT_TUSER_W-1:0] m_tuser,   // [0] status
  output logic                             m_tlast
);
  import ccsb_pkg::*;

  // Number of bitmap words that are emitted, and the index of the final one.
  localparam int NUM_WORDS = (ALPHABET_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam logic [WIDX_W-1:0]  LAST_W = WIDX_W'(NUM_WORDS - 1);
  localparam logic [CHAR_W:0]    ALPHA  = (CHAR_W + 1)'(ALPHABET_SIZE);
  localparam logic [WORD_BITS-1:0] ONES = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE,
    S_COUNT,
    S_EMIT,
    S_ERR
  } state_t;

  // Parser phase; the unused code falls to the first-letter behavior.
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_BODY  = 2'd1,
    PH_MINUS = 2'd2
  } phase_t;

  state_t               state;
  phase_t               phase;
  logic [WORD_BITS-1:0] bitmap [MAX_WORDS];
  logic [CHAR_W-1:0]    prev_letter;
  logic [CHAR_W-1:0]    range_end;
  logic                 range_allowed;
  logic [WIDX_W-1:0]    wcnt;
  logic [COUNT_W-1:0]   total;

  token_kind_t          kind;
  logic [CHAR_W-1:0]    tok_char;
  logic                 out_of_alpha;
  logic                 tok_error;
  logic                 out_free;
  logic                 out_load;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] range_mask;
  logic [6:0]           word_pop;

  // Population count as two levels: byte counts, then their sum.
  function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
    logic [3:0] byte_cnt [8];
    logic [6:0] sum;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[b*8+k]);
      end
    end
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      sum = sum + 7'(byte_cnt[b]);
    end
    return sum;
  endfunction

  assign kind         = token_kind_t'(s_tuser);
  assign tok_char     = s_tdata[CHAR_W-1:0];
  assign out_of_alpha = {1'b0, tok_char} >= ALPHA;
  assign out_free     = !m_tvalid || m_tready;
  // A result word is loaded into the output register in this cycle.
  assign out_load     = out_free && ((state == S_EMIT) || (state == S_ERR));
  assign s_tready     = (state == S_IDLE);

  // Syntax check of the current token against the parser phase.
  always_comb begin
    case (phase)
      PH_BODY: begin
        tok_error = (kind == TOK_OTHER) ||
                    ((kind == TOK_LETTER) && out_of_alpha) ||
                    ((kind == TOK_MINUS) && !range_allowed);
      end
      PH_MINUS: begin
        tok_error = (kind != TOK_LETTER) || out_of_alpha ||
                    (prev_letter > tok_char);
      end
      default: begin
        tok_error = (kind != TOK_LETTER) || out_of_alpha;
      end
    endcase
  end

  // Shared word unit: the selected word, its range mask and its member count.
  assign cur_word   = bitmap[wcnt];
  assign range_mask = ((wcnt == prev_letter[7:6]) ? (ONES << prev_letter[5:0]) : ONES) &
                      ((wcnt == range_end[7:6]) ? (ONES >> (~range_end[5:0])) : ONES);
  assign word_pop   = popcount64(cur_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_FIRST;
      bitmap        <= '{default: '0};
      prev_letter   <= '0;
      range_end     <= '0;
      range_allowed <= 1'b0;
      wcnt          <= '0;
      total         <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
      m_tuser       <= '0;
      m_tlast       <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (tok_error) begin
              bitmap        <= '{default: '0};
              prev_letter   <= '0;
              range_allowed <= 1'b0;
              phase         <= PH_FIRST;
              state         <= S_ERR;
            end else begin
              case (phase)
                PH_BODY: begin
                  case (kind)
                    TOK_LETTER: begin
                      bitmap[tok_char[7:6]][tok_char[5:0]] <= 1'b1;
                      prev_letter   <= tok_char;
                      range_allowed <= 1'b1;
                    end
                    TOK_MINUS: begin
                      phase <= PH_MINUS;
                    end
                    default: begin
                      // Closing bracket: count members, then emit.
                      wcnt  <= '0;
                      total <= '0;
                      state <= S_COUNT;
                    end
                  endcase
                end
                PH_MINUS: begin
                  range_end     <= tok_char;
                  wcnt          <= prev_letter[7:6];
                  range_allowed <= 1'b0;
                  phase         <= PH_BODY;
                  state         <= S_RANGE;
                end
                default: begin
                  bitmap[tok_char[7:6]][tok_char[5:0]] <= 1'b1;
                  prev_letter   <= tok_char;
                  range_allowed <= 1'b1;
                  phase         <= PH_BODY;
                end
              endcase
            end
          end
        end
        S_RANGE: begin
          bitmap[wcnt] <= cur_word | range_mask;
          if (wcnt == range_end[7:6]) begin
            state <= S_IDLE;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_COUNT: begin
          total <= total + COUNT_W'(word_pop);
          if (wcnt == LAST_W) begin
            wcnt  <= '0;
            state <= S_EMIT;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tuser  <= STATUS_CLASS;
            m_tdata  <= {5'd0, total, cur_word, wcnt};
            m_tlast  <= (wcnt == LAST_W);
            if (wcnt == LAST_W) begin
              bitmap        <= '{default: '0};
              prev_letter   <= '0;
              range_allowed <= 1'b0;
              phase         <= PH_FIRST;
              wcnt          <= '0;
              state         <= S_IDLE;
            end else begin
              wcnt <= wcnt + 1'b1;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tuser  <= STATUS_ERROR;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An error result carries an empty payload and closes the expression.
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_ERROR) |-> (m_tdata == '0 && m_tlast))
    else $error("error result with nonzero payload or without last");

  // The final class word is the last slice of the alphabet.
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_CLASS && m_tlast) |-> (m_tdata[1:0] == LAST_W))
    else $error("last class word has wrong word index");

  // The member count cannot exceed the alphabet.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[74:66]} <= {1'b0, ALPHA}))
    else $error("member count exceeds alphabet size");

  // A range sweep never walks past the word that holds its end.
  a_range_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANGE) |-> (wcnt <= range_end[7:6] && wcnt >= prev_letter[7:6]))
    else $error("range sweep outside its words");

  // A closing bracket inside the body starts the count pass.
  a_bracket_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && phase == PH_BODY && kind == TOK_BRACKET)
      |=> (state == S_COUNT && wcnt == '0 && total == '0))
    else $error("closing bracket did not start the count pass");

endmodule
